[rtl/core/fsd_pkg.sv]
// fsd_pkg: types, operation codes and constants for the forth stack datapath
// no dependencies
`timescale 1ns / 1ps
package fsd_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int CELL_BITS_DEF   = 64;

  typedef enum logic [5:0] {
    OP_PUSH = 6'd0, OP_DUP = 6'd1, OP_OVER = 6'd2, OP_DROP = 6'd3,
    OP_DROPS = 6'd4, OP_DUPS = 6'd5, OP_SWAP = 6'd6, OP_SWAPS = 6'd7,
    OP_ADD = 6'd8, OP_SUB = 6'd9, OP_MUL = 6'd10, OP_DIV = 6'd11,
    OP_MOD = 6'd12, OP_INC = 6'd13, OP_DEC = 6'd14, OP_INCS = 6'd15,
    OP_DECS = 6'd16, OP_NE = 6'd17, OP_EQ = 6'd18, OP_GT = 6'd19,
    OP_LT = 6'd20, OP_UGT = 6'd21, OP_TOR = 6'd22, OP_RFROM = 6'd23,
    OP_RAT = 6'd24, OP_DROPR = 6'd25, OP_DROPR4 = 6'd26, OP_TOX = 6'd27,
    OP_XFROM = 6'd28, OP_X1 = 6'd29, OP_X2 = 6'd30, OP_X3 = 6'd31,
    OP_X4 = 6'd32, OP_XDROP = 6'd33, OP_I = 6'd34
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_DIV0 = 2'd1, ERR_OVER = 2'd2, ERR_UNDER = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DIV, S_MUL, S_WRITE, S_FETCH, S_OUT
  } state_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic signed [63:0] literal;
  } in_beat_t;

  typedef struct packed {
    logic signed [63:0] top;
    logic signed [63:0] next_value;
    logic [8:0]  data_depth;
    logic [8:0]  return_depth;
    logic [8:0]  extra_depth;
    logic [1:0]  error;
  } out_beat_t;

endpackage

[rtl/core/forth_stack_datapath.sv]
// forth_stack_datapath: top level, sequencer around one alu, a serial divider
// and four stack memories; depends on fsd_pkg, fsd_stack_mem, fsd_divider
`timescale 1ns / 1ps
// One operation per beat. An item goes from acceptance to the result beat
// through read of the stack memories, execute with write back, fetch of the
// new second item and output, and the block returns to idle before it takes
// the next beat; SWAPS adds a write state for the second write.
// Multiply, divide and mod pass through the bit-serial shift-add multiplier
// and the restoring divider. The block takes no new beat until the result beat
// has been taken. Overflow and underflow leave every stack unchanged; divide
// by zero empties all three stacks.
module forth_stack_datapath #(
  parameter int STACK_DEPTH = fsd_pkg::STACK_DEPTH_DEF,
  parameter int CELL_BITS   = fsd_pkg::CELL_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fsd_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fsd_pkg::out_beat_t  out_data
);
  import fsd_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = AW + 1;
  localparam int MW = $clog2(CELL_BITS + 1);
  localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH);

  state_t state_r, state_nxt;
  logic [5:0] kind_r, kind_nxt;
  logic [CELL_BITS-1:0] lit_r, lit_nxt, top_r, top_nxt;
  logic [PW-1:0] dp_r, dp_nxt, rp_r, rp_nxt, xp_r, xp_nxt;
  logic [1:0] err_r, err_nxt;
  logic swap2_r, swap2_nxt;
  logic [CELL_BITS-1:0] hold_r, hold_nxt;
  logic [CELL_BITS-1:0] mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt, acc_r, acc_nxt;
  logic [MW-1:0] mcnt_r, mcnt_nxt;

  logic d_we, r_we, x_we;
  logic [AW-1:0] d_wa, d_ra, r_wa, r_ra, x_wa, x_ra;
  logic [CELL_BITS-1:0] d_wd, r_wd, x_wd, d_rd, d_rd2, r_rd, x_rd;
  logic [AW-1:0] d_ra2;
  logic div_start, div_done;
  logic [CELL_BITS-1:0] div_q, div_r;

  fsd_stack_mem #(.STACK_DEPTH(STACK_DEPTH), .CELL_BITS(CELL_BITS)) u_dmem (
    .clk, .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
  // shadow copy of data memory gives the third item for SWAPS
  fsd_stack_mem #(.STACK_DEPTH(STACK_DEPTH), .CELL_BITS(CELL_BITS)) u_dmem2 (
    .clk, .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra2), .rdata(d_rd2));
  fsd_stack_mem #(.STACK_DEPTH(STACK_DEPTH), .CELL_BITS(CELL_BITS)) u_rmem (
    .clk, .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
  fsd_stack_mem #(.STACK_DEPTH(STACK_DEPTH), .CELL_BITS(CELL_BITS)) u_xmem (
    .clk, .we(x_we), .waddr(x_wa), .wdata(x_wd), .raddr(x_ra), .rdata(x_rd));
  fsd_divider #(.CELL_BITS(CELL_BITS)) u_div (
    .clk, .rst_n, .start(div_start), .dividend(d_rd), .divisor(top_r),
    .done(div_done), .quotient(div_q), .remainder(div_r));

  logic [CELL_BITS-1:0] s, t, res;
  logic [PW-1:0] xk;
  logic [CELL_BITS-1:0] xcnt;

  always_comb begin
    op_t op;
    op = op_t'(kind_r);
    state_nxt = state_r; kind_nxt = kind_r; lit_nxt = lit_r; top_nxt = top_r;
    dp_nxt = dp_r; rp_nxt = rp_r; xp_nxt = xp_r; err_nxt = err_r;
    swap2_nxt = 1'b0; hold_nxt = hold_r;
    mul_a_nxt = mul_a_r; mul_b_nxt = mul_b_r; acc_nxt = acc_r; mcnt_nxt = mcnt_r;
    d_we = 1'b0; r_we = 1'b0; x_we = 1'b0;
    d_wa = AW'(dp_r); d_wd = top_r; r_wa = AW'(rp_r); r_wd = top_r;
    x_wa = AW'(xp_r); x_wd = top_r;
    d_ra = AW'(dp_r - 1'b1); d_ra2 = AW'(dp_r - 2'd2);
    r_ra = AW'(rp_r - 1'b1); x_ra = AW'(xp_r - 1'b1);
    div_start = 1'b0;
    in_ready = 1'b0;
    s = d_rd; t = top_r;
    xk = PW'(kind_r - 6'd28);
    xcnt = top_r;
    res = '0;
    unique case (op)
      OP_ADD: res = s + t;
      OP_SUB: res = s - t;
      OP_NE:  res = t - s;
      OP_EQ:  res = CELL_BITS'(s == t);
      OP_GT:  res = CELL_BITS'($signed(s) > $signed(t));
      OP_LT:  res = CELL_BITS'($signed(s) < $signed(t));
      OP_UGT: res = CELL_BITS'(s > t);
      default: res = '0;
    endcase
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt = in_data.kind;
          lit_nxt = in_data.literal[CELL_BITS-1:0];
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        unique case (op)
          OP_X1, OP_X2, OP_X3, OP_X4: x_ra = AW'(xp_r - xk);
          OP_I: r_ra = AW'(rp_r - 2'd2);
          default: ;
        endcase
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        err_nxt = ERR_NONE;
        state_nxt = S_FETCH;
        priority if ((op == OP_DIV || op == OP_MOD) && top_r == '0) begin
          dp_nxt = '0; rp_nxt = '0; xp_nxt = '0; err_nxt = ERR_DIV0;
        end else begin
          unique case (op)
            OP_PUSH, OP_DUP:
              if (dp_r == FULL) err_nxt = ERR_OVER;
              else begin
                d_we = 1'b1; dp_nxt = dp_r + 1'b1;
                top_nxt = (op == OP_PUSH) ? lit_r : top_r;
              end
            OP_OVER, OP_DUPS:
              if (dp_r == '0) err_nxt = ERR_UNDER;
              else if (dp_r == FULL) err_nxt = ERR_OVER;
              else begin
                d_we = 1'b1; dp_nxt = dp_r + 1'b1;
                if (op == OP_OVER) top_nxt = d_rd; else d_wd = d_rd;
              end
            OP_DROP, OP_DROPS:
              if (dp_r == '0) err_nxt = ERR_UNDER;
              else begin
                dp_nxt = dp_r - 1'b1;
                if (op == OP_DROP) top_nxt = d_rd;
              end
            OP_SWAP:
              if (dp_r == '0) err_nxt = ERR_UNDER;
              else begin
                d_we = 1'b1; d_wa = AW'(dp_r - 1'b1); top_nxt = d_rd;
              end
            OP_SWAPS:
              if (dp_r < PW'(2)) err_nxt = ERR_UNDER;
              else begin
                d_we = 1'b1; d_wa = AW'(dp_r - 1'b1); d_wd = d_rd2;
                hold_nxt = d_rd; swap2_nxt = 1'b1; state_nxt = S_WRITE;
              end
            OP_ADD, OP_SUB, OP_NE, OP_EQ, OP_GT, OP_LT, OP_UGT:
              if (dp_r == '0) err_nxt = ERR_UNDER;
              else begin
                dp_nxt = dp_r - 1'b1; top_nxt = res;
              end
            OP_MUL:
              if (dp_r == '0) err_nxt = ERR_UNDER;
              else begin
                mul_a_nxt = d_rd; mul_b_nxt = top_r; acc_nxt = '0;
                mcnt_nxt = MW'(CELL_BITS); state_nxt = S_MUL;
              end
            OP_DIV, OP_MOD:
              if (dp_r == '0) err_nxt = ERR_UNDER;
              else begin
                div_start = 1'b1; state_nxt = S_DIV;
              end
            OP_INC: top_nxt = top_r + 1'b1;
            OP_DEC: top_nxt = top_r - 1'b1;
            OP_INCS, OP_DECS:
              if (dp_r == '0) err_nxt = ERR_UNDER;
              else begin
                d_we = 1'b1; d_wa = AW'(dp_r - 1'b1);
                d_wd = (op == OP_INCS) ? d_rd + 1'b1 : d_rd - 1'b1;
              end
            OP_TOR:
              if (dp_r == '0) err_nxt = ERR_UNDER;
              else if (rp_r == FULL) err_nxt = ERR_OVER;
              else begin
                r_we = 1'b1; rp_nxt = rp_r + 1'b1; dp_nxt = dp_r - 1'b1; top_nxt = d_rd;
              end
            OP_RFROM, OP_RAT:
              if (rp_r == '0) err_nxt = ERR_UNDER;
              else if (dp_r == FULL) err_nxt = ERR_OVER;
              else begin
                d_we = 1'b1; dp_nxt = dp_r + 1'b1; top_nxt = r_rd;
                if (op == OP_RFROM) rp_nxt = rp_r - 1'b1;
              end
            OP_I:
              if (rp_r < PW'(2)) err_nxt = ERR_UNDER;
              else if (dp_r == FULL) err_nxt = ERR_OVER;
              else begin
                d_we = 1'b1; dp_nxt = dp_r + 1'b1; top_nxt = r_rd;
              end
            OP_DROPR:
              if (rp_r == '0) err_nxt = ERR_UNDER; else rp_nxt = rp_r - 1'b1;
            OP_DROPR4:
              if (rp_r < PW'(4)) err_nxt = ERR_UNDER; else rp_nxt = rp_r - PW'(4);
            OP_TOX:
              if (dp_r == '0) err_nxt = ERR_UNDER;
              else if (xp_r == FULL) err_nxt = ERR_OVER;
              else begin
                x_we = 1'b1; xp_nxt = xp_r + 1'b1; dp_nxt = dp_r - 1'b1; top_nxt = d_rd;
              end
            OP_XFROM, OP_X1, OP_X2, OP_X3, OP_X4:
              if (xp_r < ((op == OP_XFROM) ? PW'(1) : xk)) err_nxt = ERR_UNDER;
              else if (dp_r == FULL) err_nxt = ERR_OVER;
              else begin
                d_we = 1'b1; dp_nxt = dp_r + 1'b1; top_nxt = x_rd;
                if (op == OP_XFROM) xp_nxt = xp_r - 1'b1;
              end
            OP_XDROP:
              if (dp_r == '0) err_nxt = ERR_UNDER;
              else if (xcnt > CELL_BITS'(xp_r)) err_nxt = ERR_UNDER;
              else begin
                xp_nxt = xp_r - PW'(xcnt); dp_nxt = dp_r - 1'b1; top_nxt = d_rd;
              end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          top_nxt = (op == OP_MOD) ? div_r : div_q;
          dp_nxt = dp_r - 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_MUL: begin
        if (mcnt_r == '0) begin
          top_nxt = acc_r;
          dp_nxt = dp_r - 1'b1;
          state_nxt = S_FETCH;
        end else begin
          if (mul_b_r[0]) acc_nxt = acc_r + mul_a_r;
          mul_a_nxt = {mul_a_r[CELL_BITS-2:0], 1'b0};
          mul_b_nxt = {1'b0, mul_b_r[CELL_BITS-1:1]};
          mcnt_nxt = mcnt_r - 1'b1;
        end
      end
      S_WRITE: begin
        d_we = 1'b1; d_wa = AW'(dp_r - 2'd2); d_wd = hold_r;
        state_nxt = S_FETCH;
      end
      S_FETCH: state_nxt = S_OUT;
      S_OUT: begin
        if (out_valid && out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      top_r <= '0;
      dp_r <= '0; rp_r <= '0; xp_r <= '0;
      err_r <= ERR_NONE;
      swap2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r <= top_nxt;
      dp_r <= dp_nxt; rp_r <= rp_nxt; xp_r <= xp_nxt;
      err_r <= err_nxt;
      swap2_r <= swap2_nxt;
      ov_r <= (state_r == S_FETCH) || (ov_r && !out_ready);
    end
    kind_r <= kind_nxt; lit_r <= lit_nxt; hold_r <= hold_nxt;
    mul_a_r <= mul_a_nxt; mul_b_r <= mul_b_nxt; acc_r <= acc_nxt; mcnt_r <= mcnt_nxt;
  end

  assign out_valid = ov_r;
  always_comb begin
    out_data.top = 64'($signed(top_r));
    out_data.next_value = (dp_r == '0) ? 64'sd0 : 64'($signed(d_rd));
    out_data.data_depth = 9'(dp_r);
    out_data.return_depth = 9'(rp_r);
    out_data.extra_depth = 9'(xp_r);
    out_data.error = err_r;
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("result outside output state");
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    dp_r <= FULL && rp_r <= FULL && xp_r <= FULL) else $error("depth past limit");
  a_swap2: assert property (@(posedge clk) disable iff (!rst_n)
    swap2_r |-> state_r == S_WRITE) else $error("second swap write lost");
`endif
endmodule

[rtl/core/fsd_divider.sv]
// fsd_divider: radix-2 restoring signed divider, one quotient bit per cycle
// depends on fsd_pkg
`timescale 1ns / 1ps
module fsd_divider #(
  parameter int CELL_BITS = fsd_pkg::CELL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [CELL_BITS-1:0] dividend,
  input  logic [CELL_BITS-1:0] divisor,
  output logic                 done,
  output logic [CELL_BITS-1:0] quotient,
  output logic [CELL_BITS-1:0] remainder
);
  import fsd_pkg::*;

  localparam int CW = $clog2(CELL_BITS + 1);

  logic [CELL_BITS-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [CELL_BITS:0]   rem_r, rem_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic                 nq_r, nq_nxt, nr_r, nr_nxt;
  logic [CELL_BITS:0]   shifted, diff;

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0; nq_nxt = nq_r; nr_nxt = nr_r;
    shifted = {rem_r[CELL_BITS-1:0], q_r[CELL_BITS-1]};
    diff = shifted - {1'b0, d_r};
    if (start) begin
      nq_nxt = dividend[CELL_BITS-1] ^ divisor[CELL_BITS-1];
      nr_nxt = dividend[CELL_BITS-1];
      q_nxt = dividend[CELL_BITS-1] ? -dividend : dividend;
      d_nxt = divisor[CELL_BITS-1] ? -divisor : divisor;
      rem_nxt = '0;
      cnt_nxt = CW'(CELL_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[CELL_BITS]) begin
        rem_nxt = diff;
        q_nxt = {q_r[CELL_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[CELL_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt; nq_r <= nq_nxt; nr_r <= nr_nxt;
  end

  assign done = done_r;
  assign quotient = nq_r ? -q_r : q_r;
  assign remainder = nr_r ? -rem_r[CELL_BITS-1:0] : rem_r[CELL_BITS-1:0];
endmodule

[rtl/core/fsd_stack_mem.sv]
// fsd_stack_mem: one stack memory, one write and one registered read port
// depends on fsd_pkg
`timescale 1ns / 1ps
module fsd_stack_mem #(
  parameter int STACK_DEPTH = fsd_pkg::STACK_DEPTH_DEF,
  parameter int CELL_BITS   = fsd_pkg::CELL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(STACK_DEPTH)-1:0] waddr,
  input  logic [CELL_BITS-1:0]           wdata,
  input  logic [$clog2(STACK_DEPTH)-1:0] raddr,
  output logic [CELL_BITS-1:0]           rdata
);
  import fsd_pkg::*;

  logic [CELL_BITS-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
